// File: hw/rtl/target_engagement_controller_macros.svh
// assertion helpers used by the engagement controller rtl
`ifndef TARGET_ENGAGEMENT_CONTROLLER_MACROS_SVH
`define TARGET_ENGAGEMENT_CONTROLLER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tec assertion failed");

// next-cycle implication, checked out of reset
`define TEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tec assertion failed");

`endif

// File: hw/rtl/tec_pkg.sv
package tec_pkg;

	typedef enum logic [1:0] {
		CMD_FRAME      = 2'd0,
		CMD_MS_TICK    = 2'd1,
		CMD_BLINK_TICK = 2'd2
	} cmd_e;

	typedef enum logic [2:0] {
		MODE_NO_TARGET  = 3'd0,
		MODE_SCAN       = 3'd1,
		MODE_TRACK      = 3'd2,
		MODE_LASER_LOST = 3'd3,
		MODE_STRIKE     = 3'd4
	} mode_e;

	typedef enum logic [1:0] {
		XDRV_NONE = 2'd0,
		XDRV_STOP = 2'd1,
		XDRV_SCAN = 2'd2
	} xdrv_e;

	typedef enum logic [2:0] {
		REG_HIT_ENTER   = 3'd0,
		REG_HIT_EXIT    = 3'd1,
		REG_STRIKE_LOCK = 3'd2,
		REG_SCAN_ENTER  = 3'd3,
		REG_SCAN_REFR   = 3'd4,
		REG_DWELL_MS    = 3'd5,
		REG_CENTER_X    = 3'd6,
		REG_CENTER_Y    = 3'd7
	} reg_idx_e;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic signed [10:0] COORD_NONE = -11'sd1;

	localparam logic [9:0]  RST_HIT_ENTER   = 10'd10;
	localparam logic [9:0]  RST_HIT_EXIT    = 10'd20;
	localparam logic [15:0] RST_STRIKE_LOCK = 16'd50;
	localparam logic [15:0] RST_SCAN_ENTER  = 16'd500;
	localparam logic [7:0]  RST_SCAN_REFR   = 8'd50;
	localparam logic [15:0] RST_DWELL_MS    = 16'd100;
	localparam logic [9:0]  RST_CENTER_X    = 10'd320;
	localparam logic [9:0]  RST_CENTER_Y    = 10'd240;

	typedef struct packed {
		logic [9:0]  win_enter_lim;
		logic [9:0]  win_exit_lim;
		logic [15:0] strike_lock_frames;
		logic [15:0] scan_enter_frames;
		logic [7:0]  scan_refresh_frames;
		logic [15:0] dwell_ms;
		logic [9:0]  center_x;
		logic [9:0]  center_y;
	} cfg_t;

	typedef struct packed {
		mode_e              state_code;
		xdrv_e              x_drive;
		logic               y_stop;
		logic               pid_reset;
		logic               track_enable;
		logic signed [11:0] dev_x;
		logic signed [11:0] dev_y;
		logic               laser_on;
	} res_t;

endpackage

// File: hw/rtl/tec_cfg.sv
module tec_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tec_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [tec_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [tec_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output tec_pkg::cfg_t                     cfg
);

	tec_pkg::cfg_t    cfg_q;
	tec_pkg::reg_idx_e idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = tec_pkg::reg_idx_e'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_enter_lim       <= tec_pkg::RST_HIT_ENTER;
			cfg_q.win_exit_lim        <= tec_pkg::RST_HIT_EXIT;
			cfg_q.strike_lock_frames  <= tec_pkg::RST_STRIKE_LOCK;
			cfg_q.scan_enter_frames   <= tec_pkg::RST_SCAN_ENTER;
			cfg_q.scan_refresh_frames <= tec_pkg::RST_SCAN_REFR;
			cfg_q.dwell_ms            <= tec_pkg::RST_DWELL_MS;
			cfg_q.center_x            <= tec_pkg::RST_CENTER_X;
			cfg_q.center_y            <= tec_pkg::RST_CENTER_Y;
		end else if (wr_en) begin
			case (idx)
				tec_pkg::REG_HIT_ENTER:   cfg_q.win_enter_lim       <= pwdata[9:0];
				tec_pkg::REG_HIT_EXIT:    cfg_q.win_exit_lim        <= pwdata[9:0];
				tec_pkg::REG_STRIKE_LOCK: cfg_q.strike_lock_frames  <= pwdata[15:0];
				tec_pkg::REG_SCAN_ENTER:  cfg_q.scan_enter_frames   <= pwdata[15:0];
				tec_pkg::REG_SCAN_REFR:   cfg_q.scan_refresh_frames <= pwdata[7:0];
				tec_pkg::REG_DWELL_MS:    cfg_q.dwell_ms            <= pwdata[15:0];
				tec_pkg::REG_CENTER_X:    cfg_q.center_x            <= pwdata[9:0];
				tec_pkg::REG_CENTER_Y:    cfg_q.center_y            <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			tec_pkg::REG_HIT_ENTER:   prdata[9:0]  = cfg_q.win_enter_lim;
			tec_pkg::REG_HIT_EXIT:    prdata[9:0]  = cfg_q.win_exit_lim;
			tec_pkg::REG_STRIKE_LOCK: prdata[15:0] = cfg_q.strike_lock_frames;
			tec_pkg::REG_SCAN_ENTER:  prdata[15:0] = cfg_q.scan_enter_frames;
			tec_pkg::REG_SCAN_REFR:   prdata[7:0]  = cfg_q.scan_refresh_frames;
			tec_pkg::REG_DWELL_MS:    prdata[15:0] = cfg_q.dwell_ms;
			tec_pkg::REG_CENTER_X:    prdata[9:0]  = cfg_q.center_x;
			tec_pkg::REG_CENTER_Y:    prdata[9:0]  = cfg_q.center_y;
			default:                  prdata       = '0;
		endcase
	end

endmodule

// File: hw/rtl/target_engagement_controller.sv
// target engagement controller
// input channel (in_valid/in_ready) carries one item: cmd selects a camera frame,
// a millisecond tick or a blink tick; frames bring target and laser spot
// coordinates (-1 for none) and system_ready
// output channel (out_valid/out_ready) returns one result per item: mode code,
// axis stop/scan commands, pid reset request, tracking enable, deviations and
// laser level; cmd 3 is taken and dropped with no result
// an item is processed in the cycle it is taken: state updates at that edge and
// the result is registered into the output register, or into the skid stage when
// the receiver stalls; throughput is one item per cycle while in_ready is high, set
// by the single compare-and-update step between input handshake and output register
// a stalled receiver fills the output register and then a one-entry skid stage;
// in_ready drops only while the skid stage holds a result
// reset (arst_n low) loads default register values, clears mode, counters but the
// lost-frame one, strike latch, dwell timer, blink pattern; empties both result stages
// configuration goes over the apb port, eight 32-bit registers at 4-byte steps

`include "target_engagement_controller_macros.svh"

module target_engagement_controller #(
	parameter int unsigned BLINK_PHASE_TICKS = 30,
	parameter int unsigned MS_BITS           = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tec_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [tec_pkg::APB_DATA_W-1:0] pwdata,
	output logic [tec_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     cmd,
	input  logic signed [10:0]             obj_x,
	input  logic signed [10:0]             obj_y,
	input  logic signed [10:0]             laser_x,
	input  logic signed [10:0]             laser_y,
	input  logic                           system_ready,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     state_code,
	output logic [1:0]                     x_drive,
	output logic                           y_stop,
	output logic                           pid_reset,
	output logic                           track_enable,
	output logic signed [11:0]             dev_x,
	output logic signed [11:0]             dev_y,
	output logic                           laser_on
);

	localparam logic [7:0] BLINK_P1 = 8'(BLINK_PHASE_TICKS);
	localparam logic [7:0] BLINK_P2 = 8'(2 * BLINK_PHASE_TICKS);
	localparam logic [7:0] BLINK_P3 = 8'(3 * BLINK_PHASE_TICKS);
	localparam logic [7:0] BLINK_P4 = 8'(4 * BLINK_PHASE_TICKS);
	localparam logic [7:0] BLINK_P5 = 8'(5 * BLINK_PHASE_TICKS);

	tec_pkg::cfg_t cfg;

	tec_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// engagement state
	tec_pkg::mode_e     mode_q, mode_n;
	logic               scan_active_q, scan_active_n;
	logic [15:0]        no_tgt_q, no_tgt_n;
	logic [7:0]         refresh_q, refresh_n;
	logic [15:0]        strike_left_q, strike_left_n;
	logic               hit_latch_q, hit_latch_n;
	logic               dwell_armed_q, dwell_armed_n;
	logic [MS_BITS-1:0] dwell_start_q, dwell_start_n;
	logic [MS_BITS-1:0] ms_count_q, ms_count_n;
	logic [7:0]         blink_q, blink_n;

	// result stages
	tec_pkg::res_t res_n, out_q, skid_q;
	logic          res_vld;
	logic          out_valid_q, skid_valid_q;
	logic          accept;

	logic               no_obj, laser_ok, in_window, fired;
	logic signed [11:0] dx, dy;
	logic [11:0]        mag_x, mag_y;
	logic [7:0]         refresh_inc, blink_inc;
	logic [MS_BITS-1:0] elapsed;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mode_n        = mode_q;
		scan_active_n = scan_active_q;
		no_tgt_n      = no_tgt_q;
		refresh_n     = refresh_q;
		strike_left_n = strike_left_q;
		hit_latch_n   = hit_latch_q;
		dwell_armed_n = dwell_armed_q;
		dwell_start_n = dwell_start_q;
		ms_count_n    = ms_count_q;
		blink_n       = blink_q;
		res_n         = '0;
		res_vld       = 1'b1;

		no_obj      = (obj_x == tec_pkg::COORD_NONE) && (obj_y == tec_pkg::COORD_NONE);
		laser_ok    = (laser_x != tec_pkg::COORD_NONE) && (laser_y != tec_pkg::COORD_NONE);
		if (laser_ok) begin
			dx = {obj_x[10], obj_x} - {laser_x[10], laser_x};
			dy = {obj_y[10], obj_y} - {laser_y[10], laser_y};
		end else begin
			dx = {obj_x[10], obj_x} - {2'b00, cfg.center_x};
			dy = {obj_y[10], obj_y} - {2'b00, cfg.center_y};
		end
		mag_x       = dx[11] ? 12'(-dx) : 12'(dx);
		mag_y       = dy[11] ? 12'(-dy) : 12'(dy);
		in_window   = (mag_x < {2'b00, cfg.win_enter_lim}) &&
		              (mag_y < {2'b00, cfg.win_enter_lim}) && system_ready;
		refresh_inc = refresh_q + 8'd1;
		blink_inc   = blink_q + 8'd1;
		elapsed     = '0;
		fired       = 1'b0;

		case (cmd)
			tec_pkg::CMD_FRAME: begin
				if (strike_left_q != '0) begin
					mode_n        = tec_pkg::MODE_STRIKE;
					strike_left_n = strike_left_q - 16'd1;
				end
				if (no_obj) begin
					mode_n        = tec_pkg::MODE_NO_TARGET;
					res_n.y_stop  = 1'b1;
					hit_latch_n   = 1'b0;
					strike_left_n = '0;
					if (!system_ready) begin
						res_n.x_drive = tec_pkg::XDRV_STOP;
					end else if (no_tgt_q < cfg.scan_enter_frames) begin
						no_tgt_n      = no_tgt_q + 16'd1;
						res_n.x_drive = tec_pkg::XDRV_STOP;
					end else begin
						scan_active_n = 1'b1;
						mode_n        = tec_pkg::MODE_SCAN;
						if (refresh_q == '0) begin
							res_n.x_drive = tec_pkg::XDRV_SCAN;
						end
						// a zero period wraps on every frame, same as one
						refresh_n = (refresh_inc >= cfg.scan_refresh_frames) ? '0 : refresh_inc;
					end
				end else if (scan_active_q) begin
					// reacquired after scanning: halt both axes, clear the pid
					res_n.x_drive   = tec_pkg::XDRV_STOP;
					res_n.y_stop    = 1'b1;
					res_n.pid_reset = 1'b1;
					scan_active_n   = 1'b0;
					no_tgt_n        = '0;
					refresh_n       = '0;
				end else begin
					no_tgt_n    = '0;
					mode_n      = laser_ok ? tec_pkg::MODE_TRACK : tec_pkg::MODE_LASER_LOST;
					res_n.dev_x = dx;
					res_n.dev_y = dy;
					if (in_window) begin
						res_n.x_drive = tec_pkg::XDRV_STOP;
						res_n.y_stop  = 1'b1;
						if (!dwell_armed_q) begin
							dwell_start_n = ms_count_q;
							dwell_armed_n = 1'b1;
						end
					end else begin
						dwell_armed_n = 1'b0;
					end
					elapsed = ms_count_q - dwell_start_n;
					fired   = dwell_armed_n && (elapsed >= MS_BITS'(cfg.dwell_ms));
					if (fired) begin
						if (!hit_latch_q && (blink_q == '0)) begin
							blink_n       = 8'd1;
							hit_latch_n   = 1'b1;
							strike_left_n = cfg.strike_lock_frames;
						end
						mode_n        = tec_pkg::MODE_STRIKE;
						res_n.x_drive = tec_pkg::XDRV_STOP;
						res_n.y_stop  = 1'b1;
						ms_count_n    = '0;
						dwell_armed_n = 1'b0;
					end else begin
						if ((mag_x > {2'b00, cfg.win_exit_lim}) ||
						    (mag_y > {2'b00, cfg.win_exit_lim})) begin
							hit_latch_n = 1'b0;
						end
						res_n.track_enable = !dwell_armed_n;
					end
				end
			end
			tec_pkg::CMD_MS_TICK: begin
				ms_count_n = ms_count_q + MS_BITS'(1);
			end
			tec_pkg::CMD_BLINK_TICK: begin
				res_n.laser_on = 1'b1;
				if (system_ready && (blink_q != '0)) begin
					blink_n = blink_inc;
					if (blink_inc <= BLINK_P1) begin
						res_n.laser_on = 1'b0;
					end else if (blink_inc <= BLINK_P2) begin
						res_n.laser_on = 1'b1;
					end else if (blink_inc <= BLINK_P3) begin
						res_n.laser_on = 1'b0;
					end else if (blink_inc <= BLINK_P4) begin
						res_n.laser_on = 1'b1;
					end else if (blink_inc <= BLINK_P5) begin
						res_n.laser_on = 1'b0;
					end else begin
						blink_n = '0;
					end
				end
			end
			default: begin
				res_vld = 1'b0;
			end
		endcase

		res_n.state_code = mode_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= tec_pkg::MODE_NO_TARGET;
			scan_active_q <= 1'b1;
			no_tgt_q      <= tec_pkg::RST_SCAN_ENTER;
			refresh_q     <= '0;
			strike_left_q <= '0;
			hit_latch_q   <= 1'b0;
			dwell_armed_q <= 1'b0;
			dwell_start_q <= '0;
			ms_count_q    <= '0;
			blink_q       <= '0;
		end else if (accept && res_vld) begin
			mode_q        <= mode_n;
			scan_active_q <= scan_active_n;
			no_tgt_q      <= no_tgt_n;
			refresh_q     <= refresh_n;
			strike_left_q <= strike_left_n;
			hit_latch_q   <= hit_latch_n;
			dwell_armed_q <= dwell_armed_n;
			dwell_start_q <= dwell_start_n;
			ms_count_q    <= ms_count_n;
			blink_q       <= blink_n;
		end
	end

	// output register with a one-entry skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_vld;
			end
		end else if (accept && res_vld) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res_n;
		end else if (accept && res_vld) begin
			skid_q <= res_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign state_code   = out_q.state_code;
	assign x_drive      = out_q.x_drive;
	assign y_stop       = out_q.y_stop;
	assign pid_reset    = out_q.pid_reset;
	assign track_enable = out_q.track_enable;
	assign dev_x        = out_q.dev_x;
	assign dev_y        = out_q.dev_y;
	assign laser_on     = out_q.laser_on;

	`TEC_ASSERT_NOW(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`TEC_ASSERT_NOW(a_blink_in_range, clk, arst_n, 1'b1, blink_q <= BLINK_P5)
	`TEC_ASSERT_NEXT(a_lost_target_unlatches, clk, arst_n,
		accept && (cmd == tec_pkg::CMD_FRAME) && no_obj,
		!hit_latch_q && (strike_left_q == '0))

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tec_pkg::*;

	localparam int         BLINK_P    = 30;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [10:0] ox;
		logic signed [10:0] oy;
		logic signed [10:0] lx;
		logic signed [10:0] ly;
		logic               rdy;
	} sensor_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            cmd = CMD_FRAME;
	logic signed [10:0]    obj_x = '0;
	logic signed [10:0]    obj_y = '0;
	logic signed [10:0]    laser_x = '0;
	logic signed [10:0]    laser_y = '0;
	logic                  system_ready = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            state_code;
	logic [1:0]            x_drive;
	logic                  y_stop;
	logic                  pid_reset;
	logic                  track_enable;
	logic signed [11:0]    dev_x;
	logic signed [11:0]    dev_y;
	logic                  laser_on;

	target_engagement_controller #(.BLINK_PHASE_TICKS(BLINK_P)) dut (.*);

	always #5 clk = ~clk;

	sensor_item_t sensor_items[$];
	res_t         expected_reports[$];
	sensor_item_t next_item;
	res_t         seen, want;
	int           mismatch_count = 0;
	int           accepted_count = 0;
	int           rx_hold_left = 0;
	logic         rx_hold_done = 1'b0;
	logic         tx_steady = 1'b0;
	logic         rx_steady = 1'b0;

	// shadow of the controller: registers and engagement state
	cfg_t cfg_shadow = '{RST_HIT_ENTER, RST_HIT_EXIT, RST_STRIKE_LOCK, RST_SCAN_ENTER,
		RST_SCAN_REFR, RST_DWELL_MS, RST_CENTER_X, RST_CENTER_Y};
	mode_e       mode_now = MODE_NO_TARGET;
	logic        scanning = 1'b1;
	logic [15:0] lost_frames = RST_SCAN_ENTER;
	logic [7:0]  refresh_cnt = '0;
	logic [15:0] lock_left = '0;
	logic        strike_held = 1'b0;
	logic        dwell_armed = 1'b0;
	logic [31:0] dwell_t0 = '0;
	logic [31:0] ms_now = '0;
	logic [7:0]  blink_cnt = '0;

	function automatic res_t predict_engagement(input logic [1:0] c,
			input logic signed [10:0] ox, input logic signed [10:0] oy,
			input logic signed [10:0] lx, input logic signed [10:0] ly, input logic rdy);
		res_t r;
		int   dx, dy, adx, ady;
		r = '0;
		dx = 0;
		dy = 0;
		if (c == CMD_MS_TICK) begin
			ms_now = ms_now + 1'b1;
		end else if (c == CMD_BLINK_TICK) begin
			r.laser_on = 1'b1;
			if (rdy && blink_cnt != 0) begin
				blink_cnt = blink_cnt + 1'b1;
				if (blink_cnt <= BLINK_P) r.laser_on = 1'b0;
				else if (blink_cnt <= 2 * BLINK_P) r.laser_on = 1'b1;
				else if (blink_cnt <= 3 * BLINK_P) r.laser_on = 1'b0;
				else if (blink_cnt <= 4 * BLINK_P) r.laser_on = 1'b1;
				else if (blink_cnt <= 5 * BLINK_P) r.laser_on = 1'b0;
				else begin
					blink_cnt = '0;
					r.laser_on = 1'b1;
				end
			end
		end else begin
			if (lock_left != 0) begin
				mode_now = MODE_STRIKE;
				lock_left = lock_left - 1'b1;
			end
			if (ox == COORD_NONE && oy == COORD_NONE) begin
				mode_now = MODE_NO_TARGET;
				r.y_stop = 1'b1;
				r.x_drive = XDRV_STOP;
				strike_held = 1'b0;
				lock_left = '0;
				if (rdy && lost_frames < cfg_shadow.scan_enter_frames) begin
					lost_frames = lost_frames + 1'b1;
				end else if (rdy) begin
					scanning = 1'b1;
					mode_now = MODE_SCAN;
					r.x_drive = (refresh_cnt == 0) ? XDRV_SCAN : XDRV_NONE;
					refresh_cnt = refresh_cnt + 1'b1;
					// a refresh period of zero behaves like one
					if (refresh_cnt >= cfg_shadow.scan_refresh_frames) refresh_cnt = '0;
				end
			end else if (scanning) begin
				// first target after a scan: halt both axes, clear the loop, keep the mode
				r.x_drive = XDRV_STOP;
				r.y_stop = 1'b1;
				r.pid_reset = 1'b1;
				scanning = 1'b0;
				lost_frames = '0;
				refresh_cnt = '0;
			end else begin
				lost_frames = '0;
				if (lx != COORD_NONE && ly != COORD_NONE) begin
					mode_now = MODE_TRACK;
					dx = int'(ox) - int'(lx);
					dy = int'(oy) - int'(ly);
				end else begin
					mode_now = MODE_LASER_LOST;
					dx = int'(ox) - int'(cfg_shadow.center_x);
					dy = int'(oy) - int'(cfg_shadow.center_y);
				end
				r.dev_x = dx[11:0];
				r.dev_y = dy[11:0];
				adx = (dx < 0) ? -dx : dx;
				ady = (dy < 0) ? -dy : dy;
				if (adx < int'(cfg_shadow.win_enter_lim) && ady < int'(cfg_shadow.win_enter_lim)
						&& rdy) begin
					r.x_drive = XDRV_STOP;
					r.y_stop = 1'b1;
					if (!dwell_armed) begin
						dwell_t0 = ms_now;
						dwell_armed = 1'b1;
					end
				end else begin
					dwell_armed = 1'b0;
				end
				if (dwell_armed && (ms_now - dwell_t0) >= 32'(cfg_shadow.dwell_ms)) begin
					// new strike only with the latch released and no blink running
					if (!strike_held && blink_cnt == 0) begin
						blink_cnt = 8'd1;
						strike_held = 1'b1;
						lock_left = cfg_shadow.strike_lock_frames;
					end
					mode_now = MODE_STRIKE;
					r.x_drive = XDRV_STOP;
					r.y_stop = 1'b1;
					ms_now = '0;
					dwell_armed = 1'b0;
				end else begin
					if (adx > int'(cfg_shadow.win_exit_lim) || ady > int'(cfg_shadow.win_exit_lim))
						strike_held = 1'b0;
					r.track_enable = !dwell_armed;
				end
			end
		end
		r.state_code = mode_now;
		return r;
	endfunction

	function automatic logic signed [10:0] any_coord();
		return ($urandom_range(9) == 0) ? COORD_NONE : 11'($urandom_range(1023));
	endfunction

	function automatic logic signed [10:0] jitter_coord(input int base, input int spread);
		int v;
		v = base + int'($urandom_range(2 * spread)) - spread;
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return 11'(v);
	endfunction

	task automatic queue_item(input logic [1:0] c, input int ox, input int oy,
			input int lx, input int ly, input logic rdy);
		sensor_items.push_back('{c, 11'(ox), 11'(oy), 11'(lx), 11'(ly), rdy});
	endtask

	task automatic queue_traffic(input int n);
		int made, pick, len, bx, by, lx, ly, spread;
		logic [1:0] c;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(99);
			len = 0;
			if (pick < 45) begin
				// target hovering near the spot, or near the centre when the spot is lost
				lx = $urandom_range(1023);
				ly = $urandom_range(1023);
				bx = lx;
				by = ly;
				case ($urandom_range(7))
					0: begin
						lx = -1;
						ly = -1;
					end
					1: lx = -1;
					2: ly = -1;
					default: ;
				endcase
				if (lx == -1 || ly == -1) begin
					bx = cfg_shadow.center_x;
					by = cfg_shadow.center_y;
				end
				spread = (cfg_shadow.win_enter_lim < 40) ? int'(cfg_shadow.win_enter_lim) + 3 : 43;
				len = $urandom_range(12, 3);
				repeat (len) begin
					if ($urandom_range(99) < 35)
						queue_item(CMD_MS_TICK, any_coord(), any_coord(), any_coord(), any_coord(),
							1'($urandom_range(1)));
					else
						queue_item(CMD_FRAME, jitter_coord(bx, spread), jitter_coord(by, spread),
							lx, ly, $urandom_range(99) < 92);
				end
			end else if (pick < 60) begin
				len = $urandom_range(8, 1);
				repeat (len)
					queue_item(CMD_FRAME, -1, -1, any_coord(), any_coord(), $urandom_range(99) < 90);
			end else if (pick < 78) begin
				len = $urandom_range(40, 5);
				repeat (len)
					queue_item(CMD_BLINK_TICK, any_coord(), any_coord(), any_coord(), any_coord(),
						$urandom_range(99) < 95);
			end else begin
				repeat ($urandom_range(4, 1)) begin
					c = ($urandom_range(19) == 0) ? CMD_UNUSED : 2'($urandom_range(2));
					queue_item(c, any_coord(), any_coord(), any_coord(), any_coord(),
						1'($urandom_range(1)));
					if (c != CMD_UNUSED) len++;
				end
			end
			made += len;
		end
	endtask

	task automatic wait_idle();
		while (!(sensor_items.size() == 0 && !in_valid && expected_reports.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HIT_ENTER:   cfg_shadow.win_enter_lim = val[9:0];
			REG_HIT_EXIT:    cfg_shadow.win_exit_lim = val[9:0];
			REG_STRIKE_LOCK: cfg_shadow.strike_lock_frames = val[15:0];
			REG_SCAN_ENTER:  cfg_shadow.scan_enter_frames = val[15:0];
			REG_SCAN_REFR:   cfg_shadow.scan_refresh_frames = val[7:0];
			REG_DWELL_MS:    cfg_shadow.dwell_ms = val[15:0];
			REG_CENTER_X:    cfg_shadow.center_x = val[9:0];
			REG_CENTER_Y:    cfg_shadow.center_y = val[9:0];
			default: ;
		endcase
	endtask

	task automatic reconfigure(input int ent, input int ext, input int lock, input int scan_en,
			input int refr, input int dwell, input int cx, input int cy);
		wait_idle();
		apb_write(REG_HIT_ENTER, ent);
		apb_write(REG_HIT_EXIT, ext);
		apb_write(REG_STRIKE_LOCK, lock);
		apb_write(REG_SCAN_ENTER, scan_en);
		apb_write(REG_SCAN_REFR, refr);
		apb_write(REG_DWELL_MS, dwell);
		apb_write(REG_CENTER_X, cx);
		apb_write(REG_CENTER_Y, cy);
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				if (cmd != CMD_UNUSED)
					expected_reports.push_back(predict_engagement(cmd, obj_x, obj_y, laser_x,
						laser_y, system_ready));
				accepted_count <= accepted_count + 1;
			end
			if (!in_valid || in_ready) begin
				if (sensor_items.size() != 0 && (tx_steady || $urandom_range(99) >= 33)) begin
					next_item = sensor_items.pop_front();
					in_valid <= 1'b1;
					cmd <= next_item.cmd;
					obj_x <= next_item.ox;
					obj_y <= next_item.oy;
					laser_x <= next_item.lx;
					laser_y <= next_item.ly;
					system_ready <= next_item.rdy;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver stall partway through, so the result stages fill and in_ready drops
	always @(posedge clk) begin
		if (!rx_hold_done && accepted_count == 450) begin
			rx_hold_left <= 200;
			rx_hold_done <= 1'b1;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen = '{mode_e'(state_code), xdrv_e'(x_drive), y_stop, pid_reset, track_enable,
					dev_x, dev_y, laser_on};
				if (expected_reports.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result transaction with nothing expected", $time);
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					if (seen.state_code !== want.state_code || seen.x_drive !== want.x_drive
							|| seen.y_stop !== want.y_stop || seen.pid_reset !== want.pid_reset
							|| seen.track_enable !== want.track_enable || seen.dev_x !== want.dev_x
							|| seen.dev_y !== want.dev_y || seen.laser_on !== want.laser_on) begin
						if (mismatch_count < 10)
							$display({"%0t: mismatch exp mode %0d xdrv %0d ystop %0b pid %0b trk %0b",
								" dev %0d,%0d laser %0b | got mode %0d xdrv %0d ystop %0b pid %0b",
								" trk %0b dev %0d,%0d laser %0b"}, $time,
								want.state_code, want.x_drive, want.y_stop, want.pid_reset,
								want.track_enable, want.dev_x, want.dev_y, want.laser_on,
								seen.state_code, seen.x_drive, seen.y_stop, seen.pid_reset,
								seen.track_enable, seen.dev_x, seen.dev_y, seen.laser_on);
						mismatch_count++;
					end
				end
			end
			out_ready <= (rx_hold_left == 0) && (rx_steady || $urandom_range(99) >= 33);
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: controller starts with the scan flag set and the lost-frame count already full
		queue_item(CMD_MS_TICK, 0, 0, 0, 0, 1'b1);
		queue_item(CMD_BLINK_TICK, 1023, 1023, 1023, 1023, 1'b1);
		queue_item(CMD_UNUSED, 5, 5, 5, 5, 1'b1);
		queue_item(CMD_FRAME, -1, -1, -1, -1, 1'b0);
		queue_item(CMD_FRAME, -1, -1, 100, 100, 1'b1);
		queue_item(CMD_FRAME, -1, -1, 0, 0, 1'b1);
		queue_item(CMD_FRAME, 320, 240, -1, -1, 1'b1);
		queue_item(CMD_FRAME, 1023, 1023, 0, 0, 1'b1);
		queue_item(CMD_FRAME, 0, 0, 1023, 1023, 1'b1);
		queue_item(CMD_FRAME, -1, 500, 10, 10, 1'b1);
		queue_item(CMD_FRAME, 325, 245, -1, 100, 1'b1);
		queue_item(CMD_MS_TICK, -1, -1, -1, -1, 1'b0);
		queue_item(CMD_FRAME, 300, 250, 290, -1, 1'b1);
		queue_item(CMD_FRAME, 0, 0, -1, -1, 1'b1);
		queue_item(CMD_FRAME, 1023, -1, 5, 5, 1'b1);
		queue_item(CMD_FRAME, 504, 498, 500, 500, 1'b0);
		queue_item(CMD_FRAME, 504, 498, 500, 500, 1'b1);
		queue_item(CMD_BLINK_TICK, 0, 0, 0, 0, 1'b0);
		queue_item(CMD_MS_TICK, 0, 0, 0, 0, 1'b1);
		queue_item(CMD_FRAME, -1, -1, 7, 7, 1'b1);
		queue_item(CMD_UNUSED, -1, -1, -1, -1, 1'b0);
		queue_item(CMD_FRAME, -1, -1, -1, -1, 1'b1);
		queue_traffic(80);

		reconfigure(30, 45, 5, 3, 0, 3, 1023, 0);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		queue_traffic(220);

		reconfigure(1023, 1023, 0, 0, 255, 0, 512, 512);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		queue_traffic(200);

		reconfigure(0, 0, 65535, 65535, 1, 65535, 0, 0);
		queue_traffic(100);

		reconfigure(12, 20, 20, 6, 3, 5, 320, 240);
		queue_traffic(300);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
